// ----- design/msstt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msstt_pkg
// Shared constants, codes and control structs of the timer table.
// ----------------------------------------------------------------------------
package msstt_pkg;

   // Table geometry.
   localparam int SLOTS     = 32;
   localparam int FIRES     = 8;
   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int LIVE_W    = $clog2(SLOTS + 1);
   localparam int FIRE_W    = $clog2(FIRES + 1);

   // Field widths.
   localparam int DELAY_W   = 27;
   localparam int ID_W      = 32;
   localparam int TIME_W    = 64;
   localparam int DCNT_W    = $clog2(TIME_W);

   // Delay limits in milliseconds.
   localparam logic [DELAY_W-1:0] MIN_DELAY = DELAY_W'(5);
   localparam logic [DELAY_W-1:0] MAX_DELAY = DELAY_W'(24 * 60 * 60 * 1000);

   // Request types.
   localparam logic [1:0] REQ_CREATE  = 2'd0;
   localparam logic [1:0] REQ_CANCEL  = 2'd1;
   localparam logic [1:0] REQ_QUERY   = 2'd2;
   localparam logic [1:0] REQ_PROCESS = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DELAY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTACT   = 2'd3;

   // Response selections loaded into the result register.
   localparam logic [2:0] RSP_BAD       = 3'd0;
   localparam logic [2:0] RSP_FULL      = 3'd1;
   localparam logic [2:0] RSP_CREATE_OK = 3'd2;
   localparam logic [2:0] RSP_CANCEL    = 3'd3;
   localparam logic [2:0] RSP_QUERY     = 3'd4;
   localparam logic [2:0] RSP_NOFIRE    = 3'd5;
   localparam logic [2:0] RSP_PEND_MID  = 3'd6;
   localparam logic [2:0] RSP_PEND_LAST = 3'd7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       scan_start;
      logic       scan_step;
      logic       clear_done;
      logic       create_write;
      logic       cancel_clear;
      logic       oneshot_clear;
      logic       done_set;
      logic       div_start;
      logic       div_step;
      logic       adv_write;
      logic       pend_push;
      logic       rsp_load;
      logic [2:0] rsp_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] req_type;
      logic       delay_bad;
      logic       table_full;
      logic       scan_end;
      logic       found;
      logic       best_periodic;
      logic       div_end;
      logic       pend_vld;
      logic       fire_last;
      logic       rsp_taken;
   } stat_type;

endpackage

// ----- design/msstt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msstt_ctrl
// Controller state machine: sequences scans, updates, the remainder unit
// and result beats of the timer table.
// ----------------------------------------------------------------------------
module msstt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  msstt_pkg::stat_type stat,
   output msstt_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_SCAN   = 4'd2;
   localparam logic [3:0] S_APPLY  = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_ADV    = 4'd5;
   localparam logic [3:0] S_FNEXT  = 4'd6;
   localparam logic [3:0] S_FLAST  = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [3:0] ret_ff, ret_in;

   // The input side is open only while nothing is in progress.
   assign req_stall = (state_ff != S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.req_type)
               msstt_pkg::REQ_CREATE: begin
                  if (stat.delay_bad) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = msstt_pkg::RSP_BAD;
                     ret_in       = S_IDLE;
                     state_in     = S_RESP;
                  end else if (stat.table_full) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = msstt_pkg::RSP_FULL;
                     ret_in       = S_IDLE;
                     state_in     = S_RESP;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               msstt_pkg::REQ_PROCESS: begin
                  cmd.clear_done = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
               default: begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_end) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            ret_in = S_IDLE;
            case (stat.req_type)
               msstt_pkg::REQ_CREATE: begin
                  cmd.rsp_load = 1'b1;
                  if (stat.found) begin
                     cmd.create_write = 1'b1;
                     cmd.rsp_sel      = msstt_pkg::RSP_CREATE_OK;
                  end else begin
                     cmd.rsp_sel = msstt_pkg::RSP_FULL;
                  end
                  state_in = S_RESP;
               end
               msstt_pkg::REQ_CANCEL: begin
                  cmd.cancel_clear = stat.found;
                  cmd.rsp_load     = 1'b1;
                  cmd.rsp_sel      = msstt_pkg::RSP_CANCEL;
                  state_in         = S_RESP;
               end
               msstt_pkg::REQ_QUERY: begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = msstt_pkg::RSP_QUERY;
                  state_in     = S_RESP;
               end
               default: begin
                  if (!stat.found) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = stat.pend_vld ? msstt_pkg::RSP_PEND_LAST
                                                  : msstt_pkg::RSP_NOFIRE;
                     state_in     = S_RESP;
                  end else begin
                     cmd.done_set = 1'b1;
                     if (stat.best_periodic) begin
                        cmd.div_start = 1'b1;
                        state_in      = S_DIV;
                     end else begin
                        cmd.oneshot_clear = 1'b1;
                        state_in          = S_FNEXT;
                     end
                  end
               end
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_end) begin
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            cmd.adv_write = 1'b1;
            state_in      = S_FNEXT;
         end
         S_FNEXT: begin
            // A held firing goes out first; it is not the last one.
            if (stat.pend_vld) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = msstt_pkg::RSP_PEND_MID;
               ret_in       = S_FNEXT;
               state_in     = S_RESP;
            end else begin
               cmd.pend_push = 1'b1;
               if (stat.fire_last) begin
                  state_in = S_FLAST;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_FLAST: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = msstt_pkg::RSP_PEND_LAST;
            ret_in       = S_IDLE;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_taken) begin
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

// ----- design/msstt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msstt_dp
// Datapath: slot memories, valid bits, scan compare, bit-serial remainder
// unit for the periodic advance, and the result register.
// ----------------------------------------------------------------------------
module msstt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  msstt_pkg::cmd_type            cmd,
   output msstt_pkg::stat_type           stat,
   input  logic [1:0]                    req_type,
   input  logic                          req_periodic,
   input  logic [msstt_pkg::DELAY_W-1:0] req_delay_ms,
   input  logic [msstt_pkg::ID_W-1:0]    req_timer_id,
   input  logic [msstt_pkg::TIME_W-1:0]  req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [msstt_pkg::ID_W-1:0]    rsp_result_id,
   output logic                          rsp_is_active,
   output logic                          rsp_fired,
   output logic                          rsp_last
);

   localparam int SLOTS   = msstt_pkg::SLOTS;
   localparam int IDX_W   = msstt_pkg::IDX_W;
   localparam int CNT_W   = msstt_pkg::CNT_W;
   localparam int LIVE_W  = msstt_pkg::LIVE_W;
   localparam int FIRE_W  = msstt_pkg::FIRE_W;
   localparam int DELAY_W = msstt_pkg::DELAY_W;
   localparam int ID_W    = msstt_pkg::ID_W;
   localparam int TIME_W  = msstt_pkg::TIME_W;
   localparam int DCNT_W  = msstt_pkg::DCNT_W;

   // Captured request.
   logic [1:0]         type_ff;
   logic               per_req_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic [ID_W-1:0]    id_ff;
   logic [TIME_W-1:0]  now_ff;

   // Per-slot flags and slot memories.
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [SLOTS-1:0]   per_ff;
   logic [SLOTS-1:0]   done_ff;
   logic [ID_W-1:0]    ident_mem [SLOTS];
   logic [TIME_W-1:0]  dl_mem    [SLOTS];
   logic [DELAY_W-1:0] iv_mem    [SLOTS];

   logic [ID_W-1:0]    next_id_ff;
   logic [LIVE_W-1:0]  live_ff, live_in;

   // Scan pipeline.
   logic [CNT_W-1:0]   cnt_ff;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [ID_W-1:0]    rd_ident_ff;
   logic [TIME_W-1:0]  rd_dl_ff;
   logic [DELAY_W-1:0] rd_iv_ff;
   logic               issue;
   logic               hit;

   logic               found_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [ID_W-1:0]    best_ident_ff;
   logic [TIME_W-1:0]  best_dl_ff;
   logic [DELAY_W-1:0] best_iv_ff;

   // Remainder unit and advance.
   logic [TIME_W-1:0]  dvd_ff;
   logic [DELAY_W-1:0] div_iv_ff;
   logic [DELAY_W-1:0] rem_ff;
   logic [DCNT_W-1:0]  dcnt_ff;
   logic [DELAY_W:0]   trial;
   logic [DELAY_W:0]   trial_sub;
   logic [DELAY_W:0]   step;
   logic [TIME_W:0]    adv_sum;
   logic [TIME_W-1:0]  adv_dl;
   logic [TIME_W:0]    cre_sum;
   logic [TIME_W-1:0]  cre_dl;

   // Pending firing and result register.
   logic               pend_vld_ff;
   logic [ID_W-1:0]    pend_id_ff;
   logic [FIRE_W-1:0]  nfire_ff;
   logic               rsp_valid_ff;
   logic               rsp_taken;

   assign issue     = cmd.scan_step && (cnt_ff < CNT_W'(SLOTS));
   assign rsp_taken = rsp_valid_ff && !rsp_stall;

   // Compare stage of the scan for the current request type.
   always_comb begin
      case (type_ff)
         msstt_pkg::REQ_CREATE: hit = !found_ff && !valid_ff[rd_idx_ff];
         msstt_pkg::REQ_PROCESS: hit = valid_ff[rd_idx_ff] && !done_ff[rd_idx_ff] &&
                                      (rd_dl_ff <= now_ff) &&
                                      (!found_ff || (rd_ident_ff > best_ident_ff));
         default: hit = !found_ff && valid_ff[rd_idx_ff] && (rd_ident_ff == id_ff);
      endcase
   end

   // Restoring remainder step and saturating deadline sums.
   assign trial     = {rem_ff, dvd_ff[TIME_W-1]};
   assign trial_sub = trial - {1'b0, div_iv_ff};
   assign step      = {1'b0, div_iv_ff} - {1'b0, rem_ff};
   assign adv_sum   = {1'b0, now_ff} + (TIME_W + 1)'(step);
   assign adv_dl    = adv_sum[TIME_W] ? {TIME_W{1'b1}} : adv_sum[TIME_W-1:0];
   assign cre_sum   = {1'b0, now_ff} + (TIME_W + 1)'(delay_ff);
   assign cre_dl    = cre_sum[TIME_W] ? {TIME_W{1'b1}} : cre_sum[TIME_W-1:0];

   // Valid bits and live count next values.
   always_comb begin
      valid_in = valid_ff;
      live_in  = live_ff;
      if (cmd.create_write) begin
         valid_in[best_idx_ff] = 1'b1;
         live_in               = live_ff + LIVE_W'(1);
      end
      if (cmd.cancel_clear || cmd.oneshot_clear) begin
         valid_in[best_idx_ff] = 1'b0;
         if (live_ff != '0) begin
            live_in = live_ff - LIVE_W'(1);
         end
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff    <= req_type;
         per_req_ff <= req_periodic;
         delay_ff   <= req_delay_ms;
         id_ff      <= req_timer_id;
         now_ff     <= req_now_ms;
      end
   end

   // Slot memories: one write port, one registered read at the scan index.
   always_ff @(posedge clock) begin
      if (cmd.create_write) begin
         ident_mem[best_idx_ff] <= next_id_ff;
         dl_mem[best_idx_ff]    <= cre_dl;
         iv_mem[best_idx_ff]    <= delay_ff;
      end else if (cmd.adv_write) begin
         dl_mem[best_idx_ff] <= adv_dl;
      end
      if (issue) begin
         rd_ident_ff <= ident_mem[cnt_ff[IDX_W-1:0]];
         rd_dl_ff    <= dl_mem[cnt_ff[IDX_W-1:0]];
         rd_iv_ff    <= iv_mem[cnt_ff[IDX_W-1:0]];
         rd_idx_ff   <= cnt_ff[IDX_W-1:0];
      end
   end

   // Slot flags, counters and scan control.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         per_ff      <= '0;
         done_ff     <= '0;
         next_id_ff  <= ID_W'(1);
         live_ff     <= '0;
         cnt_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         found_ff    <= 1'b0;
         pend_vld_ff <= 1'b0;
         nfire_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         live_ff  <= live_in;
         if (cmd.create_write) begin
            per_ff[best_idx_ff] <= per_req_ff;
            next_id_ff          <= next_id_ff + ID_W'(1);
         end
         if (cmd.clear_done) begin
            done_ff     <= '0;
            nfire_ff    <= '0;
            pend_vld_ff <= 1'b0;
         end
         if (cmd.done_set) begin
            done_ff[best_idx_ff] <= 1'b1;
         end
         if (cmd.scan_start) begin
            cnt_ff    <= '0;
            rd_vld_ff <= 1'b0;
            found_ff  <= 1'b0;
         end else if (cmd.scan_step) begin
            rd_vld_ff <= issue;
            if (issue) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
            if (rd_vld_ff && hit) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.pend_push) begin
            pend_vld_ff <= 1'b1;
            nfire_ff    <= nfire_ff + FIRE_W'(1);
         end else if (cmd.rsp_load && (cmd.rsp_sel == msstt_pkg::RSP_PEND_MID ||
                                       cmd.rsp_sel == msstt_pkg::RSP_PEND_LAST)) begin
            pend_vld_ff <= 1'b0;
         end
      end
   end

   // Best candidate of the scan.
   always_ff @(posedge clock) begin
      if (cmd.scan_step && rd_vld_ff && hit) begin
         best_idx_ff   <= rd_idx_ff;
         best_ident_ff <= rd_ident_ff;
         best_dl_ff    <= rd_dl_ff;
         best_iv_ff    <= rd_iv_ff;
      end
      if (cmd.pend_push) begin
         pend_id_ff <= best_ident_ff;
      end
   end

   // Remainder of (now - deadline) by the interval, one bit a cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dvd_ff    <= now_ff - best_dl_ff;
         div_iv_ff <= (best_iv_ff == '0) ? DELAY_W'(1) : best_iv_ff;
         rem_ff    <= '0;
         dcnt_ff   <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[TIME_W-2:0], 1'b0};
         rem_ff  <= trial_sub[DELAY_W] ? trial[DELAY_W-1:0] : trial_sub[DELAY_W-1:0];
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_taken) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result fields, each written once per load.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         case (cmd.rsp_sel)
            msstt_pkg::RSP_BAD: begin
               rsp_status    <= msstt_pkg::ST_DELAY;
               rsp_result_id <= '0;
               rsp_is_active <= 1'b0;
               rsp_fired     <= 1'b0;
               rsp_last      <= 1'b1;
            end
            msstt_pkg::RSP_FULL: begin
               rsp_status    <= msstt_pkg::ST_FULL;
               rsp_result_id <= '0;
               rsp_is_active <= 1'b0;
               rsp_fired     <= 1'b0;
               rsp_last      <= 1'b1;
            end
            msstt_pkg::RSP_CREATE_OK: begin
               rsp_status    <= msstt_pkg::ST_OK;
               rsp_result_id <= next_id_ff;
               rsp_is_active <= 1'b0;
               rsp_fired     <= 1'b0;
               rsp_last      <= 1'b1;
            end
            msstt_pkg::RSP_CANCEL: begin
               rsp_status    <= found_ff ? msstt_pkg::ST_OK : msstt_pkg::ST_NOTACT;
               rsp_result_id <= '0;
               rsp_is_active <= 1'b0;
               rsp_fired     <= 1'b0;
               rsp_last      <= 1'b1;
            end
            msstt_pkg::RSP_QUERY: begin
               rsp_status    <= msstt_pkg::ST_OK;
               rsp_result_id <= '0;
               rsp_is_active <= found_ff;
               rsp_fired     <= 1'b0;
               rsp_last      <= 1'b1;
            end
            msstt_pkg::RSP_PEND_MID: begin
               rsp_status    <= msstt_pkg::ST_OK;
               rsp_result_id <= pend_id_ff;
               rsp_is_active <= 1'b0;
               rsp_fired     <= 1'b1;
               rsp_last      <= 1'b0;
            end
            msstt_pkg::RSP_PEND_LAST: begin
               rsp_status    <= msstt_pkg::ST_OK;
               rsp_result_id <= pend_id_ff;
               rsp_is_active <= 1'b0;
               rsp_fired     <= 1'b1;
               rsp_last      <= 1'b1;
            end
            default: begin
               rsp_status    <= msstt_pkg::ST_OK;
               rsp_result_id <= '0;
               rsp_is_active <= 1'b0;
               rsp_fired     <= 1'b0;
               rsp_last      <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Status to the controller.
   assign stat.req_type      = type_ff;
   assign stat.delay_bad     = (delay_ff < msstt_pkg::MIN_DELAY) ||
                               (delay_ff > msstt_pkg::MAX_DELAY);
   assign stat.table_full    = (live_ff >= LIVE_W'(SLOTS));
   assign stat.scan_end      = cmd.scan_step && rd_vld_ff &&
                               (rd_idx_ff == IDX_W'(SLOTS - 1));
   assign stat.found         = found_ff;
   assign stat.best_periodic = per_ff[best_idx_ff];
   assign stat.div_end       = (dcnt_ff == DCNT_W'(TIME_W - 1));
   assign stat.pend_vld      = pend_vld_ff;
   assign stat.fire_last     = (nfire_ff == FIRE_W'(msstt_pkg::FIRES - 1));
   assign stat.rsp_taken     = rsp_taken;

endmodule

// ----- design/multi_slot_software_timer_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_software_timer_table_top
// Table of one-shot and periodic millisecond timers with create, cancel,
// query and process requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              beat
//  req_      in         req_valid / req_stall  type, periodic, delay, id, now
//  rsp_      out        rsp_valid / rsp_stall  status, id, active, fired, last
//
// One request is in progress at a time. Create, cancel and query sweep the
// slot memory at most once. Process sweeps once per firing, and once more
// when fewer than FIRES fire; each periodic advance adds a bit-serial
// remainder. Stalled result beats add to this. Reset is synchronous and
// needs no clearing pass. A stalled result beat holds the block until it
// is taken.
// ----------------------------------------------------------------------------
module multi_slot_software_timer_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic                          req_periodic,
   input  logic [msstt_pkg::DELAY_W-1:0] req_delay_ms,
   input  logic [msstt_pkg::ID_W-1:0]    req_timer_id,
   input  logic [msstt_pkg::TIME_W-1:0]  req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [msstt_pkg::ID_W-1:0]    rsp_result_id,
   output logic                          rsp_is_active,
   output logic                          rsp_fired,
   output logic                          rsp_last
);

   msstt_pkg::cmd_type  cmd;
   msstt_pkg::stat_type stat;

   // Controller.
   msstt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath.
   msstt_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_type      (req_type),
      .req_periodic  (req_periodic),
      .req_delay_ms  (req_delay_ms),
      .req_timer_id  (req_timer_id),
      .req_now_ms    (req_now_ms),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_result_id (rsp_result_id),
      .rsp_is_active (rsp_is_active),
      .rsp_fired     (rsp_fired),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table testbench
// Drives create, cancel, query and process requests into the timer table.
// Each result beat is checked against a model of the table that runs in
// step with the requests. Both sides insert random gaps, and one phase
// holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   import msstt_pkg::*;

   localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int          CYCLE_LIMIT = 4000000;

   // A result beat as the table is expected to produce it.
   typedef struct packed {
      logic [1:0]      status;
      logic [ID_W-1:0] result_id;
      logic            is_active;
      logic            fired;
      logic            last;
   } timer_rsp_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_type;
   logic                req_periodic;
   logic [DELAY_W-1:0]  req_delay_ms;
   logic [ID_W-1:0]     req_timer_id;
   logic [TIME_W-1:0]   req_now_ms;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_status;
   logic [ID_W-1:0]     rsp_result_id;
   logic                rsp_is_active;
   logic                rsp_fired;
   logic                rsp_last;

   // Model copy of the table.
   logic               mdl_valid    [SLOTS];
   logic               mdl_periodic [SLOTS];
   logic [ID_W-1:0]    mdl_ident    [SLOTS];
   logic [TIME_W-1:0]  mdl_deadline [SLOTS];
   logic [DELAY_W-1:0] mdl_interval [SLOTS];
   logic [ID_W-1:0]    mdl_next_id;
   int                 mdl_live;

   timer_rsp_type pending_rsp[$];
   int         error_count;
   int         beats_checked;
   int         cycle_count;
   int         hold_cycles;
   bit         rsp_gaps_on;
   logic [63:0] clock_ms;

   multi_slot_software_timer_table_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_periodic  (req_periodic),
      .req_delay_ms  (req_delay_ms),
      .req_timer_id  (req_timer_id),
      .req_now_ms    (req_now_ms),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_result_id (rsp_result_id),
      .rsp_is_active (rsp_is_active),
      .rsp_fired     (rsp_fired),
      .rsp_last      (rsp_last)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // Clears the model to its reset state.
   task automatic model_reset();
      for (int i = 0; i < SLOTS; i++) begin
         mdl_valid[i]    = 1'b0;
         mdl_periodic[i] = 1'b0;
      end
      mdl_next_id = 1;
      mdl_live    = 0;
   endtask

   // Returns the index of the lowest valid slot holding the id, or -1.
   function automatic int lookup_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (mdl_valid[i] && mdl_ident[i] == id) return i;
      return -1;
   endfunction

   // Next deadline strictly after now, in whole intervals, saturating.
   function automatic logic [63:0] next_deadline(logic [63:0] dl, logic [63:0] iv,
                                                 logic [63:0] now);
      logic [63:0] step;
      if (dl > now) return dl;
      if (iv == 0) iv = 1;
      step = iv - ((now - dl) % iv);
      if (now > TIME_MAX - step) return TIME_MAX;
      return now + step;
   endfunction

   function automatic timer_rsp_type make_rsp(logic [1:0] st, logic [ID_W-1:0] id,
                                              logic act, logic fir, logic lst);
      timer_rsp_type r;
      r.status = st; r.result_id = id; r.is_active = act; r.fired = fir;
      r.last = lst;
      return r;
   endfunction

   // Applies one request to the model and queues the result beats it causes.
   task automatic predict_timer(logic [1:0] kind, logic per, logic [DELAY_W-1:0] dly,
                                logic [ID_W-1:0] id, logic [63:0] now);
      int  s;
      int  n;
      bit  done [SLOTS];
      timer_rsp_type beats[$];
      case (kind)
         REQ_CREATE: begin
            if (dly < MIN_DELAY || dly > MAX_DELAY) begin
               pending_rsp.push_back(make_rsp(ST_DELAY, 0, 0, 0, 1));
            end else begin
               s = -1;
               if (mdl_live < SLOTS)
                  for (int i = 0; i < SLOTS; i++)
                     if (!mdl_valid[i] && s < 0) s = i;
               if (s < 0) begin
                  pending_rsp.push_back(make_rsp(ST_FULL, 0, 0, 0, 1));
               end else begin
                  mdl_valid[s]    = 1'b1;
                  mdl_periodic[s] = per;
                  mdl_ident[s]    = mdl_next_id;
                  mdl_interval[s] = dly;
                  mdl_deadline[s] = (now > TIME_MAX - 64'(dly)) ? TIME_MAX : now + 64'(dly);
                  mdl_next_id     = mdl_next_id + 1;
                  mdl_live++;
                  pending_rsp.push_back(make_rsp(ST_OK, mdl_ident[s], 0, 0, 1));
               end
            end
         end
         REQ_CANCEL: begin
            s = lookup_slot(id);
            if (s < 0) begin
               pending_rsp.push_back(make_rsp(ST_NOTACT, 0, 0, 0, 1));
            end else begin
               mdl_valid[s] = 1'b0;
               if (mdl_live > 0) mdl_live--;
               pending_rsp.push_back(make_rsp(ST_OK, 0, 0, 0, 1));
            end
         end
         REQ_QUERY: begin
            pending_rsp.push_back(make_rsp(ST_OK, 0, lookup_slot(id) >= 0, 0, 1));
         end
         default: begin
            // Fire due timers, greatest id first, each at most once.
            for (int i = 0; i < SLOTS; i++) done[i] = 0;
            for (n = 0; n < FIRES; n++) begin
               s = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (mdl_valid[i] && !done[i] && mdl_deadline[i] <= now)
                     if (s < 0 || mdl_ident[i] > mdl_ident[s]) s = i;
               end
               if (s < 0) break;
               done[s] = 1;
               if (mdl_periodic[s]) begin
                  mdl_deadline[s] = next_deadline(mdl_deadline[s], 64'(mdl_interval[s]), now);
               end else begin
                  mdl_valid[s] = 1'b0;
                  if (mdl_live > 0) mdl_live--;
               end
               beats.push_back(make_rsp(ST_OK, mdl_ident[s], 0, 1, 0));
            end
            if (beats.size() == 0) begin
               pending_rsp.push_back(make_rsp(ST_OK, 0, 0, 0, 1));
            end else begin
               beats[beats.size()-1].last = 1'b1;
               foreach (beats[k]) pending_rsp.push_back(beats[k]);
            end
         end
      endcase
   endtask

   // Prints one mismatch line and counts it.
   task automatic report_error(string what);
      error_count++;
      $display("ERROR at cycle %0d: %s", cycle_count, what);
   endtask

   // Offers one beat on the request side and waits until it is accepted.
   // Valid is dropped after each accepted beat before the next one is offered.
   task automatic send_request(logic [1:0] kind, logic per, logic [DELAY_W-1:0] dly,
                               logic [ID_W-1:0] id, logic [63:0] now);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_periodic <= per;
      req_delay_ms <= dly;
      req_timer_id <= id;
      req_now_ms   <= now;
      do @(posedge clock); while (req_stall);
      predict_timer(kind, per, dly, id, now);
      @(negedge clock);
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Result side stall: random gaps, or a long hold while one is requested.
   initial begin
      int gap;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         gap = rsp_gaps_on ? $urandom_range(0, 7) : 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   // Checks each accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      timer_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (pending_rsp.size() == 0) begin
            report_error($sformatf("unexpected beat id=%0d", rsp_result_id));
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_status !== exp_rsp.status)
               report_error($sformatf("status %0d, expected %0d", rsp_status,
                                      exp_rsp.status));
            if (rsp_result_id !== exp_rsp.result_id)
               report_error($sformatf("result_id %0d, expected %0d", rsp_result_id,
                                      exp_rsp.result_id));
            if (rsp_is_active !== exp_rsp.is_active)
               report_error($sformatf("is_active %0b, expected %0b", rsp_is_active,
                                      exp_rsp.is_active));
            if (rsp_fired !== exp_rsp.fired)
               report_error($sformatf("fired %0b, expected %0b", rsp_fired,
                                      exp_rsp.fired));
            if (rsp_last !== exp_rsp.last)
               report_error($sformatf("last %0b, expected %0b", rsp_last, exp_rsp.last));
         end
      end
   end

   // Picks an id that is live about half the time.
   function automatic logic [ID_W-1:0] pick_id();
      int s;
      s = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 1) && mdl_valid[s]) return mdl_ident[s];
      if ($urandom_range(0, 3) == 0) return $urandom;
      return ID_W'($urandom_range(0, mdl_next_id + 1));
   endfunction

   // Boundary delays, errors, full table, saturation and repeated firing.
   task automatic test_directed();
      send_request(REQ_CREATE, 0, 4, 0, 0);
      send_request(REQ_CREATE, 0, MAX_DELAY + 1, 0, 0);
      send_request(REQ_CREATE, 1, '1, 0, 0);
      send_request(REQ_CREATE, 0, 0, 0, 0);
      send_request(REQ_CREATE, 0, MIN_DELAY, 0, 100);
      send_request(REQ_CREATE, 1, MAX_DELAY, 0, TIME_MAX - 10);
      send_request(REQ_CREATE, 1, MIN_DELAY, 0, 100);
      send_request(REQ_QUERY, 0, 0, 1, 0);
      send_request(REQ_QUERY, 0, 0, '1, 0);
      send_request(REQ_CANCEL, 1, '1, 1, '1);
      send_request(REQ_CANCEL, 0, 0, 1, 0);
      send_request(REQ_QUERY, 0, 0, 1, 0);
      send_request(REQ_PROCESS, 0, 0, 0, 0);
      // A periodic timer overdue by many intervals fires once.
      send_request(REQ_PROCESS, 0, 0, 0, 1000);
      // Saturated deadline is due only at the top of time.
      send_request(REQ_PROCESS, 0, 0, 0, TIME_MAX);
      send_request(REQ_PROCESS, 0, 0, 0, TIME_MAX);
      // Fill the table, then show that a bad delay beats table full.
      while (mdl_live < SLOTS) send_request(REQ_CREATE, 0, MIN_DELAY, 0, 0);
      send_request(REQ_CREATE, 0, 1, 0, 0);
      send_request(REQ_CREATE, 1, MIN_DELAY, 0, 0);
      // More due timers than one process can fire.
      send_request(REQ_PROCESS, 0, 0, 0, 64'd10);
      send_request(REQ_PROCESS, 0, 0, 0, '1);
      send_request(REQ_PROCESS, 0, 0, 0, '1);
      send_request(REQ_PROCESS, 0, 0, 0, '1);
      send_request(REQ_PROCESS, 0, 0, 0, '1);
   endtask

   // Random traffic over a moving clock, mostly well-formed.
   task automatic test_random(int count);
      int          pick;
      logic [DELAY_W-1:0] dly;
      logic [63:0] now;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         clock_ms = clock_ms + 64'($urandom_range(0, 40));
         now = clock_ms;
         if ($urandom_range(0, 19) == 0) now = {$urandom, $urandom};
         if (pick < 40) begin
            dly = DELAY_W'($urandom_range(MIN_DELAY, 120));
            if ($urandom_range(0, 9) == 0) dly = DELAY_W'($urandom);
            if ($urandom_range(0, 19) == 0) dly = DELAY_W'($urandom_range(0, 4));
            send_request(REQ_CREATE, 1'($urandom), dly, $urandom, now);
         end else if (pick < 55) begin
            send_request(REQ_CANCEL, 1'($urandom), DELAY_W'($urandom), pick_id(),
                         {$urandom, $urandom});
         end else if (pick < 70) begin
            send_request(REQ_QUERY, 1'($urandom), DELAY_W'($urandom), pick_id(),
                         {$urandom, $urandom});
         end else begin
            send_request(REQ_PROCESS, 1'($urandom), DELAY_W'($urandom), $urandom, now);
         end
      end
   endtask

   // Receiver holds off while requests keep coming, so the block backs up.
   task automatic test_backpressure();
      hold_cycles = 600;
      for (int k = 0; k < 6; k++)
         send_request(REQ_CREATE, k[0], DELAY_W'(MIN_DELAY + k), 0, clock_ms);
      send_request(REQ_PROCESS, 0, 0, 0, clock_ms + 200);
   endtask

   // Waits for all results and a tail matching the longest process.
   task automatic drain();
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (FIRES * (SLOTS + 70) + 50) @(posedge clock);
   endtask

   initial begin
      error_count   = 0;
      beats_checked = 0;
      cycle_count   = 0;
      hold_cycles   = 0;
      rsp_gaps_on   = 1;
      clock_ms      = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = REQ_CREATE;
      req_periodic  = 1'b0;
      req_delay_ms  = '0;
      req_timer_id  = '0;
      req_now_ms    = '0;
      model_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      rsp_gaps_on = 0;
      test_random(100);
      rsp_gaps_on = 1;
      test_random(260);
      drain();

      $display("Checked %0d result beats from about 420 requests of all four kinds,",
               beats_checked);
      $display("including delay limits, a full table, saturation and a long hold.");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// ----- files.f -----
design/msstt_pkg.sv
design/msstt_ctrl.sv
design/msstt_dp.sv
design/multi_slot_software_timer_table_top.sv
dv/testbench.sv
